/* rtl/osc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package osc_pkg;

	localparam int MAX_TAGS = 16;
	localparam int TAG_W = $clog2(MAX_TAGS + 2);
	localparam int IDX_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [3:0] K_ADDR = 4'd0;
	localparam logic [3:0] K_INT = 4'd1;
	localparam logic [3:0] K_FLOAT = 4'd2;
	localparam logic [3:0] K_STR = 4'd3;
	localparam logic [3:0] K_BLEN = 4'd4;
	localparam logic [3:0] K_BBYTE = 4'd5;
	localparam logic [3:0] K_T = 4'd6;
	localparam logic [3:0] K_F = 4'd7;
	localparam logic [3:0] K_N = 4'd8;
	localparam logic [3:0] K_I = 4'd9;
	localparam logic [3:0] K_OK = 4'd10;
	localparam logic [3:0] K_ERR = 4'd11;

	localparam logic [3:0] E_ADDR = 4'd1;
	localparam logic [3:0] E_BUNDLE = 4'd2;
	localparam logic [3:0] E_NO_SLASH = 4'd3;
	localparam logic [3:0] E_NO_TAGS = 4'd4;
	localparam logic [3:0] E_TRUNC_I = 4'd5;
	localparam logic [3:0] E_TRUNC_F = 4'd6;
	localparam logic [3:0] E_TRUNC_S = 4'd7;
	localparam logic [3:0] E_TRUNC_B = 4'd8;
	localparam logic [3:0] E_BAD_TAG = 4'd9;
	localparam logic [3:0] E_TOO_MANY = 4'd10;

	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [3:0] {
		TC_I = 4'd0,
		TC_F = 4'd1,
		TC_S = 4'd2,
		TC_B = 4'd3,
		TC_TRUE = 4'd4,
		TC_FALSE = 4'd5,
		TC_NIL = 4'd6,
		TC_INF = 4'd7,
		TC_BAD = 4'd8
	} tag_cls_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic end_of_packet;
	} in_item_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [31:0] data;
		logic [3:0] arg_index;
		logic [3:0] error_code;
		logic last_of_run;
	} out_item_t;

	typedef struct packed {
		logic push;
		out_item_t item;
	} osc_wr_t;

	function automatic tag_cls_t classify(logic [7:0] b);
		tag_cls_t c;
		case (b)
			8'h69: c = TC_I;
			8'h66: c = TC_F;
			8'h73: c = TC_S;
			8'h62: c = TC_B;
			8'h54: c = TC_TRUE;
			8'h46: c = TC_FALSE;
			8'h4e: c = TC_NIL;
			8'h49: c = TC_INF;
			default: c = TC_BAD;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] bundle_char(logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h23;
			3'd1: c = 8'h62;
			3'd2: c = 8'h75;
			3'd3: c = 8'h6e;
			3'd4: c = 8'h64;
			3'd5: c = 8'h6c;
			3'd6: c = 8'h65;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/osc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module osc_fifo import osc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire osc_wr_t wr,
	output logic full,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_item
);

	out_item_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0] cnt_q;
	logic pop;

	assign full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item = mem_q[rp_q];
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wp_q] <= wr.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr.push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr.push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !wr.push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/osc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module osc_front import osc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_item,
	input wire logic full,
	output osc_wr_t wr
);

	typedef enum logic [11:0] {
		PH_IDLE = 12'h001,
		PH_ADDR_SLASH = 12'h002,
		PH_ADDR_OTHER = 12'h004,
		PH_ADDR_PAD = 12'h008,
		PH_TAG_FIRST = 12'h010,
		PH_TAGS = 12'h020,
		PH_PAD = 12'h040,
		PH_WORD = 12'h080,
		PH_STR = 12'h100,
		PH_BLOB = 12'h200,
		PH_DONE = 12'h400,
		PH_ERR = 12'h800
	} phase_t;

	typedef enum logic [2:0] {
		ST_BYTE = 3'b001,
		ST_DISP = 3'b010,
		ST_EOP = 3'b100
	} ctl_t;

	phase_t ph_q, ph_n;
	ctl_t st_q, st_n;
	logic [1:0] align_q, align_n;
	logic [1:0] bc_q, bc_n;
	logic [TAG_W-1:0] tcnt_q, tcnt_n;
	logic [TAG_W-1:0] tptr_q, tptr_n;
	logic [31:0] acc_q, acc_n;
	logic [30:0] blob_q, blob_n;
	logic [2:0] bmi_q, bmi_n;
	logic bmiss_q, bmiss_n;
	logic eop_q, eop_n;

	tag_cls_t cls_q [MAX_TAGS];
	logic [MAX_TAGS-1:0] pay_q;
	logic tag_we;
	tag_cls_t tag_wcls;

	logic adv;
	logic fin;
	logic eop;
	logic [7:0] b;
	logic [TAG_W-1:0] ptr1;
	tag_cls_t cur_cls;
	logic la;
	logic [31:0] acc_sh;
	logic [30:0] blob_dec;
	logic [3:0] arg_p;
	out_item_t r;
	logic em;

	assign b = in_item.packet_byte;
	assign eop = in_item.end_of_packet;
	assign ptr1 = tptr_q + 1'b1;
	assign cur_cls = (tptr_q < tcnt_q) ? cls_q[tptr_q[IDX_W-1:0]] : TC_BAD;
	assign la = (ptr1 < tcnt_q) && pay_q[ptr1[IDX_W-1:0]];
	assign acc_sh = {acc_q[23:0], b};
	assign blob_dec = blob_q - 1'b1;
	assign arg_p = 4'(tptr_q);
	assign in_ready = (st_q == ST_BYTE) && !full;
	assign adv = !full && ((st_q != ST_BYTE) || in_valid);
	assign tag_wcls = (b[7]) ? TC_BAD : classify(b);

	assign wr.push = em && adv;
	assign wr.item = r;

	function automatic phase_t enter_ph(logic [1:0] al, tag_cls_t c);
		phase_t p;
		if (al != 2'd0) begin
			p = PH_PAD;
		end else if (c == TC_S) begin
			p = PH_STR;
		end else begin
			p = PH_WORD;
		end
		return p;
	endfunction

	always_comb begin
		ph_n = ph_q;
		st_n = st_q;
		align_n = align_q;
		bc_n = bc_q;
		tcnt_n = tcnt_q;
		tptr_n = tptr_q;
		acc_n = acc_q;
		blob_n = blob_q;
		bmi_n = bmi_q;
		bmiss_n = bmiss_q;
		eop_n = eop_q;
		tag_we = 1'b0;
		em = 1'b0;
		r = '0;
		fin = 1'b1;
		case (st_q)
			ST_BYTE: begin
				align_n = align_q + 1'b1;
				eop_n = eop;
				case (ph_q)
					PH_IDLE: begin
						if (b == CH_SLASH) begin
							em = 1'b1;
							r.kind = K_ADDR;
							r.data = {24'd0, b};
							r.last_of_run = !eop;
							ph_n = PH_ADDR_SLASH;
						end else if (b == CH_NUL) begin
							em = 1'b1;
							r.kind = K_ERR;
							r.error_code = E_NO_SLASH;
							r.last_of_run = 1'b1;
							ph_n = PH_ERR;
						end else begin
							ph_n = PH_ADDR_OTHER;
							bmiss_n = (b != CH_HASH);
							bmi_n = (b != CH_HASH) ? 3'd0 : 3'd1;
						end
					end
					PH_ADDR_SLASH: begin
						if (b == CH_NUL) begin
							ph_n = (align_n == 2'd0) ? PH_TAG_FIRST : PH_ADDR_PAD;
						end else begin
							em = 1'b1;
							r.kind = K_ADDR;
							r.data = {24'd0, b};
							r.last_of_run = !eop;
						end
					end
					PH_ADDR_OTHER: begin
						if (b == CH_NUL) begin
							em = 1'b1;
							r.kind = K_ERR;
							r.error_code = (!bmiss_q && bmi_q == 3'd7) ? E_BUNDLE : E_NO_SLASH;
							r.last_of_run = 1'b1;
							ph_n = PH_ERR;
						end else if (!bmiss_q && bmi_q != 3'd7 && b == bundle_char(bmi_q)) begin
							bmi_n = bmi_q + 1'b1;
						end else begin
							bmiss_n = 1'b1;
						end
					end
					PH_ADDR_PAD: begin
						if (align_n == 2'd0) begin
							ph_n = PH_TAG_FIRST;
						end
					end
					PH_TAG_FIRST: begin
						if (b == CH_COMMA) begin
							ph_n = PH_TAGS;
						end else begin
							em = 1'b1;
							r.kind = K_ERR;
							r.error_code = E_NO_TAGS;
							r.last_of_run = 1'b1;
							ph_n = PH_ERR;
						end
					end
					PH_TAGS: begin
						if (b == CH_NUL) begin
							tptr_n = '0;
							fin = 1'b0;
						end else if (tcnt_q >= TAG_W'(MAX_TAGS)) begin
							em = 1'b1;
							r.kind = K_ERR;
							r.error_code = E_TOO_MANY;
							r.last_of_run = 1'b1;
							ph_n = PH_ERR;
						end else begin
							tag_we = 1'b1;
							tcnt_n = tcnt_q + 1'b1;
						end
					end
					PH_PAD: begin
						if (align_n == 2'd0) begin
							ph_n = enter_ph(2'd0, cur_cls);
							bc_n = 2'd0;
							acc_n = '0;
						end
					end
					PH_WORD: begin
						acc_n = acc_sh;
						bc_n = bc_q + 1'b1;
						if (bc_q == 2'd3) begin
							em = 1'b1;
							r.arg_index = arg_p;
							r.data = acc_sh;
							if (cur_cls == TC_B) begin
								if (acc_sh[31]) begin
									r.kind = K_ERR;
									r.data = '0;
									r.error_code = E_TRUNC_B;
									r.last_of_run = 1'b1;
									ph_n = PH_ERR;
								end else begin
									r.kind = K_BLEN;
									blob_n = acc_sh[30:0];
									if (acc_sh[30:0] == '0) begin
										tptr_n = ptr1;
										fin = 1'b0;
										r.last_of_run = la && !eop;
									end else begin
										ph_n = PH_BLOB;
										r.last_of_run = !eop;
									end
								end
							end else begin
								r.kind = (cur_cls == TC_I) ? K_INT : K_FLOAT;
								tptr_n = ptr1;
								fin = 1'b0;
								r.last_of_run = la && !eop;
							end
						end
					end
					PH_STR: begin
						if (b == CH_NUL) begin
							tptr_n = ptr1;
							fin = 1'b0;
						end else begin
							em = 1'b1;
							r.kind = K_STR;
							r.data = {24'd0, b};
							r.arg_index = arg_p;
							r.last_of_run = !eop;
						end
					end
					PH_BLOB: begin
						em = 1'b1;
						r.kind = K_BBYTE;
						r.data = {24'd0, b};
						r.arg_index = arg_p;
						blob_n = blob_dec;
						if (blob_dec == '0) begin
							tptr_n = ptr1;
							fin = 1'b0;
							r.last_of_run = la && !eop;
						end else begin
							r.last_of_run = !eop;
						end
					end
					default: begin
					end
				endcase
				if (fin) begin
					st_n = eop ? ST_EOP : ST_BYTE;
				end else begin
					st_n = ST_DISP;
				end
			end
			ST_DISP: begin
				if (tptr_q >= tcnt_q) begin
					em = 1'b1;
					r.kind = K_OK;
					r.last_of_run = 1'b1;
					ph_n = PH_DONE;
				end else begin
					case (cur_cls)
						TC_TRUE, TC_FALSE, TC_NIL, TC_INF: begin
							em = 1'b1;
							case (cur_cls)
								TC_TRUE: r.kind = K_T;
								TC_FALSE: r.kind = K_F;
								TC_NIL: r.kind = K_N;
								default: r.kind = K_I;
							endcase
							r.arg_index = arg_p;
							r.last_of_run = la && !eop_q;
							tptr_n = ptr1;
							fin = 1'b0;
						end
						TC_I, TC_F, TC_S, TC_B: begin
							ph_n = enter_ph(align_q, cur_cls);
							bc_n = 2'd0;
							acc_n = '0;
						end
						default: begin
							em = 1'b1;
							r.kind = K_ERR;
							r.error_code = E_BAD_TAG;
							r.arg_index = arg_p;
							r.last_of_run = 1'b1;
							ph_n = PH_ERR;
						end
					endcase
				end
				if (fin) begin
					st_n = eop_q ? ST_EOP : ST_BYTE;
				end
			end
			ST_EOP: begin
				r.kind = K_ERR;
				r.last_of_run = 1'b1;
				case (ph_q)
					PH_ADDR_PAD, PH_TAG_FIRST, PH_TAGS: begin
						em = 1'b1;
						r.error_code = E_NO_TAGS;
					end
					PH_PAD, PH_WORD, PH_STR, PH_BLOB: begin
						em = 1'b1;
						r.arg_index = arg_p;
						case (cur_cls)
							TC_I: r.error_code = E_TRUNC_I;
							TC_F: r.error_code = E_TRUNC_F;
							TC_S: r.error_code = E_TRUNC_S;
							default: r.error_code = E_TRUNC_B;
						endcase
					end
					PH_DONE, PH_ERR: begin
						em = 1'b0;
					end
					default: begin
						em = 1'b1;
						r.error_code = E_ADDR;
					end
				endcase
				ph_n = PH_IDLE;
				align_n = '0;
				bc_n = '0;
				tcnt_n = '0;
				tptr_n = '0;
				acc_n = '0;
				blob_n = '0;
				bmi_n = '0;
				bmiss_n = 1'b0;
				eop_n = 1'b0;
				st_n = ST_BYTE;
			end
			default: begin
				st_n = ST_BYTE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && tag_we) begin
			cls_q[tcnt_q[IDX_W-1:0]] <= tag_wcls;
			pay_q[tcnt_q[IDX_W-1:0]] <= (tag_wcls == TC_I) || (tag_wcls == TC_F) ||
				(tag_wcls == TC_S) || (tag_wcls == TC_B);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			st_q <= ST_BYTE;
			align_q <= '0;
			bc_q <= '0;
			tcnt_q <= '0;
			tptr_q <= '0;
			acc_q <= '0;
			blob_q <= '0;
			bmi_q <= '0;
			bmiss_q <= 1'b0;
			eop_q <= 1'b0;
		end else if (adv) begin
			ph_q <= ph_n;
			st_q <= st_n;
			align_q <= align_n;
			bc_q <= bc_n;
			tcnt_q <= tcnt_n;
			tptr_q <= tptr_n;
			acc_q <= acc_n;
			blob_q <= blob_n;
			bmi_q <= bmi_n;
			bmiss_q <= bmiss_n;
			eop_q <= eop_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/osc_message_parser.sv */
// osc message parser
// in channel: one packet byte per request (in_item.packet_byte) with
// in_item.end_of_packet set on the packet's last byte; in_valid/in_ready.
// out channel: result requests (kind, data, arg_index, error_code,
// last_of_run) on out_valid/out_ready; last_of_run marks the final result
// caused by one input byte.
// throughput: one byte per cycle for address, tag and payload bytes while the
// result queue has room. in_ready is low while the tag dispatch sequencer
// handles each T/F/N/I tag, after the tag string ends and after each completed
// argument, and while every packet is closed.
// a result is on out right after the edge that takes its byte if the queue is
// empty; dispatch results follow one per cycle while the queue has room.
// a four-entry result queue sits between the parser and the out port, so
// the parser keeps taking bytes while the receiver stalls; in_ready also
// drops whenever that queue is full.
// reset: arst_n returns the parser to waiting for an address and empties
// the queue; the tag store holds no reset value and needs none.
`timescale 1ns / 1ps
`default_nettype none

module osc_message_parser import osc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_item,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_item
);

	osc_wr_t wr;
	logic full;

	osc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.full(full),
		.wr(wr)
	);

	osc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.full(full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

endmodule

`default_nettype wire
